>>> sv/rgb2yuv_pkg.sv
// rgb2yuv_pkg: shared types, field widths, bt.601 coefficients and the clip helper
// used by the interfaces, the per-pixel lanes, the chroma merge and the top level
`timescale 1ns / 1ps

package rgb2yuv_pkg;

  localparam int unsigned PIXEL_W = 16;
  localparam int unsigned WORD_W  = 16;
  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned SUM_W   = 18;  // signed products plus rounding term
  localparam int unsigned OFS_W   = 11;  // shifted sum plus offset, signed

  // luma
  localparam logic signed [SUM_W-1:0] CY_R = 18'sd66;
  localparam logic signed [SUM_W-1:0] CY_G = 18'sd129;
  localparam logic signed [SUM_W-1:0] CY_B = 18'sd25;
  // blue difference
  localparam logic signed [SUM_W-1:0] CU_R = -18'sd38;
  localparam logic signed [SUM_W-1:0] CU_G = -18'sd74;
  localparam logic signed [SUM_W-1:0] CU_B = 18'sd112;
  // red difference
  localparam logic signed [SUM_W-1:0] CV_R = 18'sd112;
  localparam logic signed [SUM_W-1:0] CV_G = -18'sd94;
  localparam logic signed [SUM_W-1:0] CV_B = -18'sd18;

  localparam logic signed [SUM_W-1:0] ROUND_TERM = 18'sd128;
  localparam logic signed [OFS_W-1:0] Y_OFFSET   = 11'sd16;
  localparam logic signed [OFS_W-1:0] C_OFFSET   = 11'sd128;
  localparam logic signed [OFS_W-1:0] CHAN_MAX   = 11'sd255;

  typedef struct packed {
    logic [CHAN_W-1:0] y;
    logic [CHAN_W-1:0] u;
    logic [CHAN_W-1:0] v;
  } yuv_t;

  // load enables handed from the top-level control to both lanes
  typedef struct packed {
    logic s1;
    logic s2;
  } pipe_en_t;

  function automatic logic [CHAN_W-1:0] clip8(input logic signed [OFS_W-1:0] val);
    logic [CHAN_W-1:0] res;
    if (val < 0) begin
      res = '0;
    end else if (val > CHAN_MAX) begin
      res = '1;
    end else begin
      res = val[CHAN_W-1:0];
    end
    return res;
  endfunction

endpackage

>>> sv/rgb2yuv_if.sv
// rgb2yuv_in_if / rgb2yuv_out_if: valid/ready channels for pixel pairs and packed words
// depends on rgb2yuv_pkg for field widths
`timescale 1ns / 1ps

interface rgb2yuv_in_if;
  logic                             valid;
  logic                             ready;
  logic [rgb2yuv_pkg::PIXEL_W-1:0]  first_pixel;
  logic [rgb2yuv_pkg::PIXEL_W-1:0]  second_pixel;

  modport source (output valid, output first_pixel, output second_pixel, input ready);
  modport sink   (input valid, input first_pixel, input second_pixel, output ready);
endinterface

interface rgb2yuv_out_if;
  logic                            valid;
  logic                            ready;
  logic [rgb2yuv_pkg::WORD_W-1:0]  first_word;
  logic [rgb2yuv_pkg::WORD_W-1:0]  second_word;

  modport source (output valid, output first_word, output second_word, input ready);
  modport sink   (input valid, input first_word, input second_word, output ready);
endinterface

>>> sv/rgb2yuv_pair_to_yuv422.sv
// rgb565_pair_to_yuv422: top level, two conversion lanes, chroma merge and flow control
// depends on rgb2yuv_pkg, rgb2yuv_if, rgb2yuv_lane, rgb2yuv_merge
`timescale 1ns / 1ps

//  channel | dir | payload                      | handshake
//  in_ch   | in  | first_pixel, second_pixel    | valid/ready, rgb565 pair
//  out_ch  | out | first_word, second_word      | valid/ready, {y0,u} and {y1,v}
//
//  one pixel pair per clock sustained while out_ch is ready; an input transfer
//  reaches out_ch through three registered stages (lane sums, lane clip, merge)
//  each stage carries its own valid bit and loads whenever it is empty or its
//  successor moves, so bubbles collapse and a stalled output only blocks input
//  once all three stages are full
//  reset (synchronous, active low) clears only the stage valid bits

module rgb565_pair_to_yuv422 (
  input  logic          clk,
  input  logic          rst_n,
  rgb2yuv_in_if.sink    in_ch,
  rgb2yuv_out_if.source out_ch
);
  import rgb2yuv_pkg::*;

  // stage valid bits: lane sums, lane clip, output register
  logic v1_r, v2_r, v3_r;
  logic v1_nxt, v2_nxt, v3_nxt;

  // stage can take a new item this cycle
  logic adv1, adv2, adv3;
  logic in_fire, ld2, ld3;

  pipe_en_t lane_en;
  yuv_t     lane0_yuv, lane1_yuv;

  assign adv3 = !v3_r || out_ch.ready;
  assign adv2 = !v2_r || adv3;
  assign adv1 = !v1_r || adv2;

  assign in_fire = in_ch.valid && adv1;
  assign ld2     = v1_r && adv2;
  assign ld3     = v2_r && adv3;

  assign lane_en.s1 = in_fire;
  assign lane_en.s2 = ld2;

  // a stage is full if it loads a new item or its own item could not move on
  assign v1_nxt = in_fire || (v1_r && !adv2);
  assign v2_nxt = ld2 || (v2_r && !adv3);
  assign v3_nxt = ld3 || (v3_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  // left pixel lane
  rgb2yuv_lane u_lane0 (
    .clk   (clk),
    .en    (lane_en),
    .pixel (in_ch.first_pixel),
    .yuv   (lane0_yuv)
  );

  // right pixel lane
  rgb2yuv_lane u_lane1 (
    .clk   (clk),
    .en    (lane_en),
    .pixel (in_ch.second_pixel),
    .yuv   (lane1_yuv)
  );

  // chroma averaging and packing into the output register
  rgb2yuv_merge u_merge (
    .clk         (clk),
    .load        (ld3),
    .lane0       (lane0_yuv),
    .lane1       (lane1_yuv),
    .first_word  (out_ch.first_word),
    .second_word (out_ch.second_word)
  );

  assign in_ch.ready  = adv1;
  assign out_ch.valid = v3_r;

  // an empty pipeline always takes a transfer
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (!v1_r && !v2_r && !v3_r) |-> in_ch.ready)
    else $error("pipeline empty but input not ready");

  // input back-pressure only when every stage holds an item
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (v1_r && v2_r && v3_r))
    else $error("input stalled with a free stage");

  // an accepted pair is held in the first stage on the next cycle
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> v1_r)
    else $error("accepted pair lost at stage one");

  // a blocked middle stage keeps its item
  a_mid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && v3_r && !out_ch.ready) |=> v2_r)
    else $error("stage two item dropped under stall");

endmodule

>>> sv/rgb2yuv_lane.sv
// rgb2yuv_lane: one rgb565 pixel to clipped y/u/v in two register stages
// depends on rgb2yuv_pkg
`timescale 1ns / 1ps

module rgb2yuv_lane (
  input  logic                            clk,
  input  rgb2yuv_pkg::pipe_en_t           en,
  input  logic [rgb2yuv_pkg::PIXEL_W-1:0] pixel,
  output rgb2yuv_pkg::yuv_t               yuv
);
  import rgb2yuv_pkg::*;

  logic signed [SUM_W-1:0] r_s, g_s, b_s;
  logic signed [SUM_W-1:0] y_sum_nxt, u_sum_nxt, v_sum_nxt;
  logic signed [SUM_W-1:0] y_sum_r, u_sum_r, v_sum_r;
  logic signed [OFS_W-1:0] y_ofs, u_ofs, v_ofs;
  yuv_t                    yuv_nxt, yuv_r;

  // widen by plain left shift, no bit replication
  assign r_s = signed'(SUM_W'({pixel[15:11], 3'b000}));
  assign g_s = signed'(SUM_W'({pixel[10:5], 2'b00}));
  assign b_s = signed'(SUM_W'({pixel[4:0], 3'b000}));

  assign y_sum_nxt = CY_R * r_s + CY_G * g_s + CY_B * b_s + ROUND_TERM;
  assign u_sum_nxt = CU_R * r_s + CU_G * g_s + CU_B * b_s + ROUND_TERM;
  assign v_sum_nxt = CV_R * r_s + CV_G * g_s + CV_B * b_s + ROUND_TERM;

  always_ff @(posedge clk) begin
    if (en.s1) begin
      y_sum_r <= y_sum_nxt;
      u_sum_r <= u_sum_nxt;
      v_sum_r <= v_sum_nxt;
    end
  end

  // arithmetic shift floors toward minus infinity
  assign y_ofs = OFS_W'(y_sum_r >>> 8) + Y_OFFSET;
  assign u_ofs = OFS_W'(u_sum_r >>> 8) + C_OFFSET;
  assign v_ofs = OFS_W'(v_sum_r >>> 8) + C_OFFSET;

  assign yuv_nxt.y = clip8(y_ofs);
  assign yuv_nxt.u = clip8(u_ofs);
  assign yuv_nxt.v = clip8(v_ofs);

  always_ff @(posedge clk) begin
    if (en.s2) begin
      yuv_r <= yuv_nxt;
    end
  end

  assign yuv = yuv_r;

endmodule

>>> sv/rgb2yuv_merge.sv
// rgb2yuv_merge: averages the chroma of both lanes and packs the two output words
// depends on rgb2yuv_pkg
`timescale 1ns / 1ps

module rgb2yuv_merge (
  input  logic                           clk,
  input  logic                           load,
  input  rgb2yuv_pkg::yuv_t              lane0,
  input  rgb2yuv_pkg::yuv_t              lane1,
  output logic [rgb2yuv_pkg::WORD_W-1:0] first_word,
  output logic [rgb2yuv_pkg::WORD_W-1:0] second_word
);
  import rgb2yuv_pkg::*;

  logic [CHAN_W:0]   u_pair, v_pair;
  logic [WORD_W-1:0] first_word_nxt, second_word_nxt;
  logic [WORD_W-1:0] first_word_r, second_word_r;

  assign u_pair = {1'b0, lane0.u} + {1'b0, lane1.u};
  assign v_pair = {1'b0, lane0.v} + {1'b0, lane1.v};

  // floor average is the top bits of the sum
  assign first_word_nxt  = {lane0.y, u_pair[CHAN_W:1]};
  assign second_word_nxt = {lane1.y, v_pair[CHAN_W:1]};

  always_ff @(posedge clk) begin
    if (load) begin
      first_word_r  <= first_word_nxt;
      second_word_r <= second_word_nxt;
    end
  end

  assign first_word  = first_word_r;
  assign second_word = second_word_r;

endmodule
